### src/acsp_pkg.sv
// Shared types and constants for the ANSI CSI escape sequence parser.
// Used by every module of the block; depends on nothing.
package acsp_pkg;

  typedef enum logic [3:0] {
    ACT_SWALLOW   = 4'd0,
    ACT_PRINT     = 4'd1,
    ACT_SET_CUR   = 4'd2,
    ACT_CLR_SCR   = 4'd3,
    ACT_CLR_LINE  = 4'd4,
    ACT_GFX_RESET = 4'd5,
    ACT_SWAP_COL  = 4'd6,
    ACT_FG_INDEX  = 4'd7,
    ACT_BG_INDEX  = 4'd8,
    ACT_FG_RGB    = 4'd9,
    ACT_BG_RGB    = 4'd10
  } action_t;

  typedef enum logic [1:0] {
    ST_OFF = 2'd0,
    ST_ESC = 2'd1,
    ST_CSI = 2'd2
  } status_t;

  localparam logic [7:0] CH_ESC   = 8'd27;
  localparam logic [7:0] CH_LBRKT = 8'h5B;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP    = 8'h41;
  localparam logic [7:0] CH_DOWN  = 8'h42;
  localparam logic [7:0] CH_RIGHT = 8'h43;
  localparam logic [7:0] CH_LEFT  = 8'h44;
  localparam logic [7:0] CH_HOME  = 8'h48;
  localparam logic [7:0] CH_ERASE = 8'h4A;
  localparam logic [7:0] CH_ELINE = 8'h4B;
  localparam logic [7:0] CH_SGR   = 8'h6D;

  localparam int SGR_FG_EXT = 38;
  localparam int SGR_BG_EXT = 48;
  localparam int SGR_FG_LO  = 30;
  localparam int SGR_BG_LO  = 40;
  localparam int SGR_SWAP   = 7;
  localparam int SGR_RGB    = 2;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] cursor_row;
    logic [15:0] cursor_col;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

  typedef struct packed {
    action_t     action;
    logic [7:0]  print_byte;
    logic [15:0] new_row;
    logic [15:0] new_col;
    logic        clear_before;
    logic        clear_after;
    logic [5:0]  color_index;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } result_t;

endpackage

### src/acsp_in_reg.sv
// Input register stage of the CSI parser.
// Depends on acsp_pkg for the item and stage types.
module acsp_in_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  acsp_pkg::item_t  in_item,
  input  logic             advance,
  output acsp_pkg::stage_t stage
);

  logic            valid_r;
  logic            valid_nxt;
  acsp_pkg::item_t item_r;
  logic            in_fire;

  assign in_ready = !valid_r || advance;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (in_fire) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= in_item;
    end
  end

  assign stage.valid = valid_r;
  assign stage.item  = item_r;

endmodule

### src/acsp_core.sv
// Parser state and per-byte decode of the CSI parser.
// Depends on acsp_pkg for types, character codes and action codes.
module acsp_core #(
  parameter int NUM_PARAMS = 8,
  parameter int PARAM_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  acsp_pkg::stage_t  stage,
  input  logic              advance,
  output acsp_pkg::result_t result
);

  localparam int IW = $clog2(NUM_PARAMS);
  localparam int XW = ((PARAM_BITS > 16) ? PARAM_BITS : 16) + 1;
  localparam int MW = PARAM_BITS + 4;

  acsp_pkg::status_t     status_r;
  acsp_pkg::status_t     status_nxt;
  logic [IW-1:0]         idx_r;
  logic [IW-1:0]         idx_nxt;
  logic [PARAM_BITS-1:0] params_r [NUM_PARAMS];
  logic                  clr_all;
  logic                  wr_en;
  logic [PARAM_BITS-1:0] wr_val;

  logic [7:0]            c;
  logic [PARAM_BITS-1:0] cur;
  logic [MW-1:0]         mac;
  logic [PARAM_BITS-1:0] sat_val;
  logic [PARAM_BITS-1:0] n_val;
  logic [XW-1:0]         n_x;
  logic [XW-1:0]         row_x;
  logic [XW-1:0]         col_x;
  logic [XW-1:0]         row_add;
  logic [XW-1:0]         col_add;
  logic [15:0]           row_up;
  logic [15:0]           col_left;
  logic [15:0]           p2_lo;
  logic [15:0]           p3_lo;
  logic [15:0]           p4_lo;
  logic                  is_digit;

  assign c        = stage.item.data_byte;
  assign cur      = params_r[idx_r];
  assign is_digit = (c >= acsp_pkg::CH_ZERO) && (c <= acsp_pkg::CH_NINE);

  assign mac     = {1'b0, cur, 3'b000} + {3'b000, cur, 1'b0} + MW'(c - acsp_pkg::CH_ZERO);
  assign sat_val = (mac[MW-1:PARAM_BITS] != '0) ? {PARAM_BITS{1'b1}} : mac[PARAM_BITS-1:0];

  assign n_val    = (cur == '0) ? PARAM_BITS'(1) : cur;
  assign n_x      = XW'(n_val);
  assign row_x    = XW'(stage.item.cursor_row);
  assign col_x    = XW'(stage.item.cursor_col);
  assign row_add  = row_x + n_x;
  assign col_add  = col_x + n_x;
  assign row_up   = (row_x >= n_x) ? 16'(row_x - n_x) : 16'd0;
  assign col_left = (col_x >= n_x) ? 16'(col_x - n_x) : 16'd0;

  generate
    if (PARAM_BITS >= 16) begin : g_wide
      assign p2_lo = params_r[2][15:0];
      assign p3_lo = params_r[3][15:0];
      assign p4_lo = params_r[4][15:0];
    end else begin : g_narrow
      assign p2_lo = 16'(params_r[2]);
      assign p3_lo = 16'(params_r[3]);
      assign p4_lo = 16'(params_r[4]);
    end
  endgenerate

  always_comb begin
    status_nxt        = status_r;
    idx_nxt           = idx_r;
    clr_all           = 1'b0;
    wr_en             = 1'b0;
    wr_val            = sat_val;
    result            = '0;
    result.action     = acsp_pkg::ACT_PRINT;
    result.print_byte = c;
    if (c == acsp_pkg::CH_ESC) begin
      status_nxt        = acsp_pkg::ST_ESC;
      idx_nxt           = '0;
      clr_all           = 1'b1;
      result.action     = acsp_pkg::ACT_SWALLOW;
      result.print_byte = '0;
    end else if (c == acsp_pkg::CH_LBRKT && status_r == acsp_pkg::ST_ESC) begin
      status_nxt        = acsp_pkg::ST_CSI;
      result.action     = acsp_pkg::ACT_SWALLOW;
      result.print_byte = '0;
    end else if (status_r == acsp_pkg::ST_CSI) begin
      if (is_digit) begin
        wr_en             = 1'b1;
        result.action     = acsp_pkg::ACT_SWALLOW;
        result.print_byte = '0;
      end else if (c == acsp_pkg::CH_SEMI) begin
        if (idx_r != IW'(NUM_PARAMS - 1)) begin
          idx_nxt = idx_r + IW'(1);
        end
        result.action     = acsp_pkg::ACT_SWALLOW;
        result.print_byte = '0;
      end else begin
        case (c)
          acsp_pkg::CH_UP, acsp_pkg::CH_DOWN, acsp_pkg::CH_RIGHT, acsp_pkg::CH_LEFT,
          acsp_pkg::CH_HOME, acsp_pkg::CH_ERASE, acsp_pkg::CH_ELINE,
          acsp_pkg::CH_SGR: begin
            status_nxt        = acsp_pkg::ST_OFF;
            result.action     = acsp_pkg::ACT_SWALLOW;
            result.print_byte = '0;
          end
          default: begin
          end
        endcase
        case (c)
          acsp_pkg::CH_UP: begin
            result.action  = acsp_pkg::ACT_SET_CUR;
            result.new_row = row_up;
            result.new_col = stage.item.cursor_col;
          end
          acsp_pkg::CH_DOWN: begin
            result.action  = acsp_pkg::ACT_SET_CUR;
            result.new_row = row_add[15:0];
            result.new_col = stage.item.cursor_col;
          end
          acsp_pkg::CH_RIGHT: begin
            result.action  = acsp_pkg::ACT_SET_CUR;
            result.new_row = stage.item.cursor_row;
            result.new_col = col_add[15:0];
          end
          acsp_pkg::CH_LEFT: begin
            result.action  = acsp_pkg::ACT_SET_CUR;
            result.new_row = stage.item.cursor_row;
            result.new_col = col_left;
          end
          acsp_pkg::CH_HOME: begin
            result.action = acsp_pkg::ACT_SET_CUR;
          end
          acsp_pkg::CH_ERASE: begin
            if (cur == PARAM_BITS'(2)) begin
              result.action = acsp_pkg::ACT_CLR_SCR;
            end
          end
          acsp_pkg::CH_ELINE: begin
            if (cur <= PARAM_BITS'(2)) begin
              result.action       = acsp_pkg::ACT_CLR_LINE;
              result.clear_before = (cur != '0);
              result.clear_after  = (cur != PARAM_BITS'(1));
            end
          end
          acsp_pkg::CH_SGR: begin
            if (idx_r == '0) begin
              if (cur == '0) begin
                result.action = acsp_pkg::ACT_GFX_RESET;
              end else if (cur == PARAM_BITS'(acsp_pkg::SGR_SWAP)) begin
                result.action = acsp_pkg::ACT_SWAP_COL;
              end else if (cur >= PARAM_BITS'(acsp_pkg::SGR_FG_LO) &&
                           cur <= PARAM_BITS'(acsp_pkg::SGR_FG_LO + 8)) begin
                result.action      = acsp_pkg::ACT_FG_INDEX;
                result.color_index = cur[5:0];
              end else if (cur >= PARAM_BITS'(acsp_pkg::SGR_BG_LO) &&
                           cur <= PARAM_BITS'(acsp_pkg::SGR_BG_LO + 8)) begin
                result.action      = acsp_pkg::ACT_BG_INDEX;
                result.color_index = cur[5:0];
              end
            end else if (idx_r == IW'(4) &&
                         params_r[1] == PARAM_BITS'(acsp_pkg::SGR_RGB) &&
                         (params_r[0] == PARAM_BITS'(acsp_pkg::SGR_FG_EXT) ||
                          params_r[0] == PARAM_BITS'(acsp_pkg::SGR_BG_EXT))) begin
              result.action = (params_r[0] == PARAM_BITS'(acsp_pkg::SGR_FG_EXT)) ?
                              acsp_pkg::ACT_FG_RGB : acsp_pkg::ACT_BG_RGB;
              result.red    = p2_lo;
              result.green  = p3_lo;
              result.blue   = p4_lo;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= acsp_pkg::ST_OFF;
      idx_r    <= '0;
      for (int i = 0; i < NUM_PARAMS; i++) begin
        params_r[i] <= '0;
      end
    end else if (advance) begin
      status_r <= status_nxt;
      idx_r    <= idx_nxt;
      if (clr_all) begin
        for (int i = 0; i < NUM_PARAMS; i++) begin
          params_r[i] <= '0;
        end
      end else if (wr_en) begin
        params_r[idx_r] <= wr_val;
      end
    end
  end

endmodule

### src/acsp_out_reg.sv
// Result register stage of the CSI parser.
// Depends on acsp_pkg for the result type.
module acsp_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  acsp_pkg::result_t result,
  output logic              out_free,
  output logic              out_valid,
  input  logic              out_ready,
  output acsp_pkg::result_t out_result
);

  logic              valid_r;
  logic              valid_nxt;
  acsp_pkg::result_t result_r;

  assign out_free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_r <= result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;

endmodule

### src/ansi_csi_sequence_parser_top.sv
// ANSI CSI escape sequence parser: one byte in, one display command out.
// Each input byte is held in the input register, its result in the result register.
// One byte per cycle flows unless out_ready stalls the result register; the decode and
// parameter update sit between the two registers, so bytes flow back to back.
// Synchronous active-low reset leaves the parser outside any sequence with all
// parameters cleared and both register stages empty.
module ansi_csi_sequence_parser_top #(
  parameter int NUM_PARAMS = 8,
  parameter int PARAM_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic [15:0] in_cursor_row,
  input  logic [15:0] in_cursor_col,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_action,
  output logic [7:0]  out_print_byte,
  output logic [15:0] out_new_row,
  output logic [15:0] out_new_col,
  output logic        out_clear_before,
  output logic        out_clear_after,
  output logic [5:0]  out_color_index,
  output logic [15:0] out_red,
  output logic [15:0] out_green,
  output logic [15:0] out_blue
);

  acsp_pkg::item_t   in_item;
  acsp_pkg::stage_t  stage;
  acsp_pkg::result_t result;
  acsp_pkg::result_t out_result;
  logic              out_free;
  logic              advance;

  assign in_item.data_byte  = in_data_byte;
  assign in_item.cursor_row = in_cursor_row;
  assign in_item.cursor_col = in_cursor_col;

  assign advance = stage.valid && out_free;

  acsp_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .advance  (advance),
    .stage    (stage)
  );

  acsp_core #(
    .NUM_PARAMS (NUM_PARAMS),
    .PARAM_BITS (PARAM_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .stage   (stage),
    .advance (advance),
    .result  (result)
  );

  acsp_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .result     (result),
    .out_free   (out_free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_result (out_result)
  );

  assign out_action       = out_result.action;
  assign out_print_byte   = out_result.print_byte;
  assign out_new_row      = out_result.new_row;
  assign out_new_col      = out_result.new_col;
  assign out_clear_before = out_result.clear_before;
  assign out_clear_after  = out_result.clear_after;
  assign out_color_index  = out_result.color_index;
  assign out_red          = out_result.red;
  assign out_green        = out_result.green;
  assign out_blue         = out_result.blue;

endmodule
